@@ sv/rrd_pkg.sv @@
// rrd_pkg: shared widths, register codes and rounding helper for the ray bounce unit
// used by the channel interfaces, the root unit and the top level
`timescale 1ns / 1ps
`default_nettype none

package rrd_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    // root unit: 40 bit radicand, 20 bit floor root
    localparam int RAD_W  = 40;
    localparam int ROOT_W = 20;

    // normal divider: |n| << FRAC_BITS plus half the length, over the length
    localparam int NUM_W = 30;
    localparam int DEN_W = 16;
    localparam int QUO_W = 15;

    localparam logic [CFG_W-1:0] INDEX_RATIO_RESET = 16'd16384;
    localparam logic [CFG_W-1:0] RAY_LENGTH_RESET  = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INDEX_RATIO = 1'b0,
        CFG_RAY_LENGTH  = 1'b1
    } cfg_index_t;

    // shift right with round to nearest, ties away from zero
    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        shr_round = v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

`default_nettype wire

@@ sv/rrd_if.sv @@
// rrd_if: valid/ready channel interfaces for ray words, result words and register writes
// depends on rrd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface rrd_in_if;
    import rrd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;
    logic signed [IN_W-1:0] norm_x;
    logic signed [IN_W-1:0] norm_y;
    logic signed [IN_W-1:0] norm_z;

    modport source (output valid, action, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                    input ready);
    modport sink (input valid, action, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                  output ready);
endinterface

interface rrd_out_if;
    import rrd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic                    total_internal;

    modport source (output valid, out_x, out_y, out_z, total_internal, input ready);
    modport sink (input valid, out_x, out_y, out_z, total_internal, output ready);
endinterface

interface rrd_cfg_if;
    import rrd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/rrd_isqrt.sv @@
// rrd_isqrt: pipelined floor square root, one root bit per register stage
// depends on rrd_pkg for RAD_W and ROOT_W
`timescale 1ns / 1ps
`default_nettype none

module rrd_isqrt (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [rrd_pkg::RAD_W-1:0]  radicand,
    output logic      [rrd_pkg::ROOT_W-1:0] root
);
    import rrd_pkg::*;

    // rem holds radicand minus root squared
    logic [RAD_W:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int B = ROOT_W - 1 - g;
        logic [RAD_W:0]    rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W:0]    trial;
        logic [RAD_W:0]    rem_next;
        logic [ROOT_W-1:0] root_next;

        if (g == 0) begin : g_first
            assign rem_in  = {1'b0, radicand};
            assign root_in = '0;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        always_comb
        begin
            // (root + 2^b)^2 - root^2
            trial = ((RAD_W+1)'(root_in) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (ROOT_W'(1) << B);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

@@ sv/ray_reflect_refract_direction_unit.sv @@
// ray_reflect_refract_direction_unit: reflection and snell refraction of a ray direction
// depends on rrd_pkg, rrd_if and rrd_isqrt
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   ray    : one word per ray, action (0 reflect, 1 refract), direction and normal, Q2.14
//   bounce : one word per ray, direction times ray_length, saturated to 32 bits,
//            and total_internal when refraction fell back to reflection
//   cfg    : register writes, index 0 index_ratio, index 1 ray_length; always ready,
//            write only while no ray is in flight
// Timing
//   a word accepted on ray passes through every stage of the pipe to bounce; one word is
//   accepted every cycle while bounce is taken. The depth comes from two 20-stage root units
//   (normal length, refraction root) and a 15-stage divider that normalizes the normal.
// Stall
//   the last stage is the output register; when it holds a word that is not taken,
//   every stage holds and ray.ready drops, so nothing is lost or repeated
// Reset
//   rst_n clears all valid bits and sets index_ratio to 1.0 and ray_length to 1

module ray_reflect_refract_direction_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    rrd_cfg_if.sink   cfg,
    rrd_in_if.sink    ray,
    rrd_out_if.source bounce
);
    import rrd_pkg::*;

    localparam int ST_IN       = 1;
    localparam int ST_PROD     = ST_IN + 1;
    localparam int ST_SUM      = ST_PROD + 1;
    localparam int ST_REFL_MUL = ST_SUM + 1;
    localparam int ST_REFL     = ST_REFL_MUL + 1;
    localparam int ST_LEN      = ST_SUM + ROOT_W + 1;
    localparam int ST_U        = ST_LEN + QUO_W;
    localparam int ST_DU       = ST_U + 1;
    localparam int ST_C        = ST_DU + 1;
    localparam int ST_CC       = ST_C + 1;
    localparam int ST_S1       = ST_CC + 1;
    localparam int ST_E2S      = ST_S1 + 1;
    localparam int ST_K        = ST_E2S + 1;
    localparam int ST_M        = ST_K + ROOT_W + 1;
    localparam int ST_MU       = ST_M + 1;
    localparam int ST_SEL      = ST_MU + 1;
    localparam int ST_SCALE    = ST_SEL + 1;
    localparam int ST_SAT      = ST_SCALE + 1;
    localparam int LAT         = ST_SAT;

    typedef struct packed {
        logic             action;
        logic [2:0][15:0] d;
        logic [2:0][15:0] n;
        logic [2:0][31:0] pp;
        logic [2:0][31:0] nn;
        logic [33:0]      dot;
        logic [31:0]      l2;
        logic [2:0][50:0] q;
        logic [2:0][21:0] rr;
        logic             len_zero;
        logic [2:0][15:0] u;
        logic [2:0][31:0] du;
        logic [17:0]      c;
        logic [33:0]      cc;
        logic [19:0]      etac;
        logic [21:0]      s1;
        logic [54:0]      e2s;
        logic [27:0]      kv;
        logic             tir;
        logic [21:0]      m;
        logic [2:0][33:0] cu;
        logic [2:0][37:0] mu;
        logic [2:0][32:0] ed;
        logic [2:0][21:0] rt;
        logic [2:0][25:0] r;
        logic [2:0][42:0] sp;
        logic [2:0][31:0] o;
    } side_t;

    logic [CFG_W-1:0] ratio_reg;
    logic [CFG_W-1:0] len_reg;
    logic [31:0]      eta2_reg;

    logic [LAT:1]     vld_reg;
    logic [LAT:1]     vld_next;
    side_t            side_reg  [1:LAT];
    side_t            side_next [1:LAT];
    logic             adv;

    logic [ROOT_W-1:0] root_len;
    logic [ROOT_W-1:0] root_k;
    logic [RAD_W-1:0]  rad_k;

    logic [NUM_W-1:0] div_num [3];
    logic [NUM_W-1:0] div_rem_reg [3][QUO_W];
    logic [QUO_W-1:0] div_quo_reg [3][QUO_W];
    logic [DEN_W-1:0] div_den_reg [QUO_W];

    // the whole pipe moves unless the output word waits
    assign adv       = !vld_reg[LAT] || bounce.ready;
    assign ray.ready = adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= INDEX_RATIO_RESET;
            len_reg   <= RAY_LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_INDEX_RATIO: ratio_reg <= cfg.data;
                CFG_RAY_LENGTH:  len_reg   <= cfg.data;
                default:         ratio_reg <= ratio_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        eta2_reg <= ratio_reg * ratio_reg;
    end

    assign vld_next = {vld_reg[LAT-1:1], ray.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            side_reg <= side_next;
    end

    rrd_isqrt u_root_len (
        .clk      (clk),
        .en       (adv),
        .radicand (RAD_W'(side_reg[ST_SUM].l2)),
        .root     (root_len)
    );

    assign rad_k = side_reg[ST_K].tir ? '0 : (RAD_W'(side_reg[ST_K].kv) << FRAC_BITS);

    rrd_isqrt u_root_k (
        .clk      (clk),
        .en       (adv),
        .radicand (rad_k),
        .root     (root_k)
    );

    // divider numerators: |n| scaled up, plus half the length for rounding
    always_comb
    begin
        logic [16:0] an;
        for (int i = 0; i < 3; i++)
        begin
            an = side_reg[ST_LEN-1].n[i][15] ? 17'(-$signed(side_reg[ST_LEN-1].n[i]))
                                               : 17'(side_reg[ST_LEN-1].n[i]);
            div_num[i] = (NUM_W'(an) << FRAC_BITS) + NUM_W'(root_len[DEN_W-1:1]);
        end
    end

    // restoring divider, one quotient bit per stage, three lanes share the divisor
    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        localparam int B = QUO_W - 1 - g;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W:0]   trial;
        logic [NUM_W-1:0] rem_in    [3];
        logic [QUO_W-1:0] quo_in    [3];
        logic [NUM_W-1:0] rem_next  [3];
        logic [QUO_W-1:0] quo_next  [3];

        if (g == 0) begin : g_first
            assign den_in = root_len[DEN_W-1:0];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = div_num[i];
                assign quo_in[i] = '0;
            end
        end
        else begin : g_rest
            assign den_in = div_den_reg[g-1];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = div_rem_reg[i][g-1];
                assign quo_in[i] = div_quo_reg[i][g-1];
            end
        end

        assign trial = (NUM_W+1)'(den_in) << B;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if ({1'b0, rem_in[i]} >= trial)
                begin
                    rem_next[i] = rem_in[i] - trial[NUM_W-1:0];
                    quo_next[i] = quo_in[i] | (QUO_W'(1) << B);
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    quo_next[i] = quo_in[i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                div_den_reg[g] <= den_in;
        end

        for (genvar i = 0; i < 3; i++) begin : g_lane_reg
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    div_rem_reg[i][g] <= rem_next[i];
                    div_quo_reg[i][g] <= quo_next[i];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [33:0] dsum;
        logic signed [33:0] etap;
        logic signed [35:0] s1t;
        logic signed [63:0] kt;
        logic signed [21:0] etac_x;
        logic signed [21:0] root_x;
        logic signed [42:0] spv;

        for (int k = 2; k <= LAT; k++)
            side_next[k] = side_reg[k-1];

        side_next[ST_IN]        = '0;
        side_next[ST_IN].action = ray.action;
        side_next[ST_IN].d[0]   = ray.dir_x;
        side_next[ST_IN].d[1]   = ray.dir_y;
        side_next[ST_IN].d[2]   = ray.dir_z;
        side_next[ST_IN].n[0]   = ray.norm_x;
        side_next[ST_IN].n[1]   = ray.norm_y;
        side_next[ST_IN].n[2]   = ray.norm_z;

        for (int i = 0; i < 3; i++)
        begin
            side_next[ST_PROD].pp[i] = $signed(side_reg[ST_IN].d[i])
                                       * $signed(side_reg[ST_IN].n[i]);
            side_next[ST_PROD].nn[i] = $signed(side_reg[ST_IN].n[i])
                                       * $signed(side_reg[ST_IN].n[i]);
        end

        side_next[ST_SUM].dot = $signed(side_reg[ST_PROD].pp[0])
                                + $signed(side_reg[ST_PROD].pp[1])
                                + $signed(side_reg[ST_PROD].pp[2]);
        side_next[ST_SUM].l2  = side_reg[ST_PROD].nn[0] + side_reg[ST_PROD].nn[1]
                                + side_reg[ST_PROD].nn[2];

        // reflection about the raw normal
        for (int i = 0; i < 3; i++)
        begin
            side_next[ST_REFL_MUL].q[i] = ($signed(side_reg[ST_SUM].dot)
                                           * $signed(side_reg[ST_SUM].n[i])) <<< 1;
            side_next[ST_REFL].rr[i] = 22'($signed(side_reg[ST_REFL_MUL].d[i])
                - shr_round(64'($signed(side_reg[ST_REFL_MUL].q[i])), 2 * FRAC_BITS));
        end

        side_next[ST_LEN].len_zero = (root_len == '0);

        // unit normal, zero when the normal has no length
        for (int i = 0; i < 3; i++)
        begin
            if (side_reg[ST_U-1].len_zero)
                side_next[ST_U].u[i] = '0;
            else if (side_reg[ST_U-1].n[i][15])
                side_next[ST_U].u[i] =
                    16'(-$signed({1'b0, div_quo_reg[i][QUO_W-1]}));
            else
                side_next[ST_U].u[i] = 16'(div_quo_reg[i][QUO_W-1]);
        end

        for (int i = 0; i < 3; i++)
            side_next[ST_DU].du[i] = $signed(side_reg[ST_U].d[i])
                                     * $signed(side_reg[ST_U].u[i]);

        dsum = $signed(side_reg[ST_DU].du[0]) + $signed(side_reg[ST_DU].du[1])
               + $signed(side_reg[ST_DU].du[2]);
        side_next[ST_C].c = 18'(shr_round(64'(dsum), FRAC_BITS));

        side_next[ST_CC].cc   = $signed(side_reg[ST_C].c) * $signed(side_reg[ST_C].c);
        etap                  = $signed({1'b0, ratio_reg}) * $signed(side_reg[ST_C].c);
        side_next[ST_CC].etac = 20'(shr_round(64'(etap), FRAC_BITS));

        s1t = $signed(36'd1 << (2 * FRAC_BITS)) - $signed({2'b00, side_reg[ST_CC].cc});
        side_next[ST_S1].s1 = 22'(shr_round(64'(s1t), FRAC_BITS));

        side_next[ST_E2S].e2s = $signed({1'b0, eta2_reg}) * $signed(side_reg[ST_S1].s1);

        // negative radicand means total internal reflection
        kt = (64'sd1 <<< FRAC_BITS)
             - shr_round(64'($signed(side_reg[ST_E2S].e2s)), 2 * FRAC_BITS);
        side_next[ST_K].kv  = 28'(kt);
        side_next[ST_K].tir = kt[63];

        etac_x = 22'($signed(side_reg[ST_M-1].etac));
        root_x = {2'b00, root_k};
        side_next[ST_M].m = -etac_x - root_x;
        for (int i = 0; i < 3; i++)
            side_next[ST_M].cu[i] = $signed(side_reg[ST_M-1].c)
                                    * $signed(side_reg[ST_M-1].u[i]);

        for (int i = 0; i < 3; i++)
        begin
            side_next[ST_MU].mu[i] = $signed(side_reg[ST_M].m) * $signed(side_reg[ST_M].u[i]);
            side_next[ST_MU].ed[i] = $signed({1'b0, ratio_reg}) * $signed(side_reg[ST_M].d[i]);
            side_next[ST_MU].rt[i] = 22'($signed(side_reg[ST_M].d[i])
                - shr_round(64'($signed(side_reg[ST_M].cu[i])) <<< 1, FRAC_BITS));
        end

        for (int i = 0; i < 3; i++)
        begin
            if (!side_reg[ST_MU].action)
                side_next[ST_SEL].r[i] = 26'($signed(side_reg[ST_MU].rr[i]));
            else if (side_reg[ST_MU].tir)
                side_next[ST_SEL].r[i] = 26'($signed(side_reg[ST_MU].rt[i]));
            else
                side_next[ST_SEL].r[i] = 26'(
                    shr_round(64'($signed(side_reg[ST_MU].mu[i])), FRAC_BITS)
                    + shr_round(64'($signed(side_reg[ST_MU].ed[i])), FRAC_BITS));
        end
        side_next[ST_SEL].tir = side_reg[ST_MU].action & side_reg[ST_MU].tir;

        for (int i = 0; i < 3; i++)
            side_next[ST_SCALE].sp[i] = $signed(side_reg[ST_SEL].r[i])
                                        * $signed({1'b0, len_reg});

        for (int i = 0; i < 3; i++)
        begin
            spv = $signed(side_reg[ST_SCALE].sp[i]);
            if (spv > $signed(43'(32'h7fff_ffff)))
                side_next[ST_SAT].o[i] = 32'h7fff_ffff;
            else if (spv < -$signed(43'(33'h1_0000_0000 >> 1)))
                side_next[ST_SAT].o[i] = 32'h8000_0000;
            else
                side_next[ST_SAT].o[i] = spv[31:0];
        end
    end

    assign bounce.valid          = vld_reg[LAT];
    assign bounce.out_x          = side_reg[LAT].o[0];
    assign bounce.out_y          = side_reg[LAT].o[1];
    assign bounce.out_z          = side_reg[LAT].o[2];
    assign bounce.total_internal = side_reg[LAT].tir;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        bounce.valid && !bounce.ready |=> $stable(vld_reg))
        else $error("pipeline moved while the output word was stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        ray.valid && ray.ready |=> vld_reg[ST_IN])
        else $error("accepted ray word did not enter the first stage");

    a_tir_refract_only: assert property (@(posedge clk) disable iff (!rst_n)
        bounce.valid && bounce.total_internal |-> side_reg[LAT].action)
        else $error("total internal flag on a reflection word");

endmodule

`default_nettype wire
